/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/lfsa_pkg.sv */
package lfsa_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int TIME_BITS_DEF = 32;
	localparam int FIELD_W       = 32;
	localparam int USE_W         = 32;
	localparam int IDX_OUT_W     = 6;
	localparam int OPEN_OUT_W    = 7;
	localparam int IN_DATA_W     = 64;
	localparam int OUT_DATA_W    = 48;

	localparam logic [USE_W-1:0] USE_MAX = '1;

	typedef struct packed {
		logic valid;
		logic placed;
	} lfsa_ctl_t;

endpackage

/* rtl/lfsa_cell.sv */
module lfsa_cell #(
	parameter int TIME_BITS = 32,
	parameter int IDX_W     = 6,
	parameter int CNT_W     = 7,
	parameter int INDEX     = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  lfsa_pkg::lfsa_ctl_t     up_ctl,
	input  logic [TIME_BITS-1:0]    up_start,
	input  logic [TIME_BITS-1:0]    up_fin,
	input  logic [IDX_W-1:0]        up_idx,
	input  logic [lfsa_pkg::USE_W-1:0] up_uses,
	input  logic [CNT_W-1:0]        up_cnt,
	output lfsa_pkg::lfsa_ctl_t     dn_ctl,
	output logic [TIME_BITS-1:0]    dn_start,
	output logic [TIME_BITS-1:0]    dn_fin,
	output logic [IDX_W-1:0]        dn_idx,
	output logic [lfsa_pkg::USE_W-1:0] dn_uses,
	output logic [CNT_W-1:0]        dn_cnt
);
	import lfsa_pkg::*;

	logic                 open_q;
	logic [TIME_BITS-1:0] end_q;
	logic [USE_W-1:0]     uses_q;
	lfsa_ctl_t            ctl_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] fin_q;
	logic [IDX_W-1:0]     idx_q;
	logic [USE_W-1:0]     uses_out_q;
	logic [CNT_W-1:0]     cnt_q;

	logic             free;
	logic             take;
	logic             open_after;
	logic [USE_W-1:0] new_uses;

	assign free       = open_q && (end_q <= up_start);
	assign take       = up_ctl.valid && !up_ctl.placed && (free || !open_q);
	assign open_after = open_q || take;
	assign new_uses   = !open_q ? USE_W'(1) :
		(uses_q == USE_MAX) ? uses_q : uses_q + USE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			ctl_q  <= '0;
		end else if (advance) begin
			if (take) begin
				open_q <= 1'b1;
			end
			ctl_q.valid  <= up_ctl.valid;
			ctl_q.placed <= up_ctl.placed || take;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (take) begin
				end_q  <= up_fin;
				uses_q <= new_uses;
			end
			start_q    <= up_start;
			fin_q      <= up_fin;
			idx_q      <= take ? IDX_W'(INDEX) : up_idx;
			uses_out_q <= take ? new_uses : up_uses;
			cnt_q      <= up_cnt + CNT_W'(open_after);
		end
	end

	assign dn_ctl   = ctl_q;
	assign dn_start = start_q;
	assign dn_fin   = fin_q;
	assign dn_idx   = idx_q;
	assign dn_uses  = uses_out_q;
	assign dn_cnt   = cnt_q;

endmodule

/* rtl/lowest_free_slot_allocator_top.sv */
// Lowest-free-slot allocator built as a chain of SLOTS cells, one per slot. A request word
// walks the chain one cell per cycle unless the output is held; the first cell that is
// open with an end time at or before the start time, or else the first unopened cell, takes
// it. Requests enter back to back, one word per cycle unless the output is held, and each
// result leaves from the register of the last cell. When the result is held at the output,
// the whole chain holds and no request is taken. A result with tuser set means every slot
// was busy and the request was dropped.
`include "assert_macros.svh"

module lowest_free_slot_allocator_top #(
	parameter int SLOTS     = lfsa_pkg::SLOTS_DEF,
	parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// start_time [31:0], end_time [63:32]
	input  logic [lfsa_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// slot_index [5:0], slot_count [37:6], slots_opened [44:38], zero [47:45]
	output logic [lfsa_pkg::OUT_DATA_W-1:0] m_tdata,
	// full_res [0]
	output logic                           m_tuser
);
	import lfsa_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	lfsa_ctl_t            ctl   [0:SLOTS];
	logic [TIME_BITS-1:0] start [0:SLOTS];
	logic [TIME_BITS-1:0] fin   [0:SLOTS];
	logic [IDX_W-1:0]     idx   [0:SLOTS];
	logic [USE_W-1:0]     uses  [0:SLOTS];
	logic [CNT_W-1:0]     cnt   [0:SLOTS];

	logic        advance;
	logic [63:0] start_wide;
	logic [63:0] fin_wide;

	assign advance  = !(ctl[SLOTS].valid && !m_tready);
	assign s_tready = advance;

	assign start_wide = {32'd0, s_tdata[FIELD_W-1:0]};
	assign fin_wide   = {32'd0, s_tdata[2*FIELD_W-1:FIELD_W]};

	assign ctl[0].valid  = s_tvalid && advance;
	assign ctl[0].placed = 1'b0;
	assign start[0]      = start_wide[TIME_BITS-1:0];
	assign fin[0]        = fin_wide[TIME_BITS-1:0];
	assign idx[0]        = '0;
	assign uses[0]       = '0;
	assign cnt[0]        = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		lfsa_cell #(
			.TIME_BITS (TIME_BITS),
			.IDX_W     (IDX_W),
			.CNT_W     (CNT_W),
			.INDEX     (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.up_ctl   (ctl[g]),
			.up_start (start[g]),
			.up_fin   (fin[g]),
			.up_idx   (idx[g]),
			.up_uses  (uses[g]),
			.up_cnt   (cnt[g]),
			.dn_ctl   (ctl[g+1]),
			.dn_start (start[g+1]),
			.dn_fin   (fin[g+1]),
			.dn_idx   (idx[g+1]),
			.dn_uses  (uses[g+1]),
			.dn_cnt   (cnt[g+1])
		);
	end

	logic                  placed;
	logic [IDX_OUT_W-1:0]  idx_out;
	logic [USE_W-1:0]      uses_out;
	logic [OPEN_OUT_W-1:0] open_out;

	assign placed   = ctl[SLOTS].placed;
	assign idx_out  = placed ? IDX_OUT_W'(idx[SLOTS]) : '0;
	assign uses_out = placed ? uses[SLOTS] : '0;
	assign open_out = OPEN_OUT_W'(cnt[SLOTS]);

	assign m_tvalid = ctl[SLOTS].valid;
	assign m_tdata  = {3'b000, open_out, uses_out, idx_out};
	assign m_tuser  = !placed;

	`ASSERT_IMP(a_full_all_open, clk, arst_n, m_tvalid && !placed,
		cnt[SLOTS] == CNT_W'(SLOTS))
	`ASSERT_IMP(a_idx_below_open, clk, arst_n, m_tvalid && placed,
		CNT_W'(idx[SLOTS]) < cnt[SLOTS])
	`ASSERT_IMP(a_uses_nonzero, clk, arst_n, m_tvalid && placed, uses[SLOTS] != '0)
	`ASSERT_NXT(a_hold_when_stalled, clk, arst_n, m_tvalid && !m_tready,
		!s_tready || !$past(s_tready))

endmodule
